// ===== design/pott_pkg.sv =====
// Package for the pulse oscillator trim tracker.
// Holds widths, register indexes, reset values and the shared structs.
// No dependencies; every other design file imports it.
package pott_pkg;

   // History depth; it must be a power of two so the average is a shift.
   localparam int AVG_DEPTH = 4;
   localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
   localparam int HOLD_W    = $clog2(AVG_DEPTH + 1);

   localparam int WIDTH_W   = 16;
   localparam int TRIM_W    = 6;
   localparam int STEP_W    = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEPT_THRESHOLD = 3'd0,
      CSR_COARSE_LOW       = 3'd1,
      CSR_COARSE_HIGH      = 3'd2,
      CSR_FINE_LOW         = 3'd3,
      CSR_FINE_HIGH        = 3'd4,
      CSR_COARSE_STEP      = 3'd5
   } csr_index_type;

   localparam logic [WIDTH_W-1:0] RST_ACCEPT_THRESHOLD = 16'd2176;
   localparam logic [WIDTH_W-1:0] RST_COARSE_LOW       = 16'd2609;
   localparam logic [WIDTH_W-1:0] RST_COARSE_HIGH      = 16'd2647;
   localparam logic [WIDTH_W-1:0] RST_FINE_LOW         = 16'd2622;
   localparam logic [WIDTH_W-1:0] RST_FINE_HIGH        = 16'd2626;
   localparam logic [STEP_W-1:0]  RST_COARSE_STEP      = 5'd10;

   // The trim is worked in offset binary: flipping the sign bit maps
   // -32..31 onto 0..63.
   localparam logic [TRIM_W-1:0] TRIM_BIAS       = 6'h20;
   localparam logic [TRIM_W-1:0] TRIM_BIASED_MAX = 6'h3f;

   localparam logic [HOLD_W-1:0] HOLD_RELOAD = HOLD_W'(AVG_DEPTH);

   typedef struct packed {
      logic [WIDTH_W-1:0] accept_threshold;
      logic [WIDTH_W-1:0] coarse_low;
      logic [WIDTH_W-1:0] coarse_high;
      logic [WIDTH_W-1:0] fine_low;
      logic [WIDTH_W-1:0] fine_high;
      logic [STEP_W-1:0]  coarse_step;
   } cfg_type;

   typedef struct packed {
      logic signed [TRIM_W-1:0] trim;
      logic                     lock;
      logic                     hold_zero;
   } decision_type;

endpackage

// ===== design/pott_if.sv =====
// Handshake interfaces for the trim tracker: request, response and
// register write channels. Depends on pott_pkg for the field widths.
interface pott_req_if import pott_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] pulse_width;

   modport source (output valid, output pulse_width, input ready);
   modport sink   (input valid, input pulse_width, output ready);
endinterface

interface pott_rsp_if import pott_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TRIM_W-1:0] trim;
   logic                     locked;
   logic                     evaluated;

   modport source (output valid, output trim, output locked, output evaluated, input ready);
   modport sink   (input valid, input trim, input locked, input evaluated, output ready);
endinterface

interface pott_csr_if import pott_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pott_decide.sv =====
// Trim decision for one evaluation: compares the average against the
// coarse and fine windows and steps the clamped trim. Uses pott_pkg.
module pott_decide import pott_pkg::*; (
   input  logic [WIDTH_W-1:0]       avg,
   input  logic signed [TRIM_W-1:0] trim_cur,
   input  logic                     lock_cur,
   input  cfg_type                  cfg,
   output decision_type             decision
);

   logic signed [7:0] biased;
   logic signed [7:0] step;
   logic signed [7:0] moved;
   logic [TRIM_W-1:0] clamped;

   assign biased = signed'({2'b00, trim_cur ^ TRIM_BIAS});
   assign step   = signed'({3'b000, cfg.coarse_step});

   always_comb begin
      moved              = biased;
      decision.lock      = lock_cur;
      decision.hold_zero = 1'b0;
      // The windows are tested in priority order; the first hit wins.
      if (avg < cfg.coarse_low) begin
         moved         = biased + step;
         decision.lock = 1'b0;
      end else if (avg > cfg.coarse_high) begin
         moved         = biased - step;
         decision.lock = 1'b0;
      end else if (avg < cfg.fine_low) begin
         moved = biased + 8'sd1;
      end else if (avg > cfg.fine_high) begin
         moved = biased - 8'sd1;
      end else begin
         decision.lock      = 1'b1;
         decision.hold_zero = 1'b1;
      end

      if (moved < 8'sd0) begin
         clamped = '0;
      end else if (moved > 8'sd63) begin
         clamped = TRIM_BIASED_MAX;
      end else begin
         clamped = moved[TRIM_W-1:0];
      end
      decision.trim = signed'(clamped ^ TRIM_BIAS);
   end

endmodule

// ===== design/pulse_oscillator_trim_tracker_top.sv =====
// Top level of the pulse oscillator trim tracker.
// Depends on pott_pkg, the channel interfaces in pott_if and pott_decide.

// One request is taken per clock cycle while the response is not stalled,
// and its response appears in the response register on the next cycle.
// Requests are taken whenever the response register is empty or is being
// emptied in the same cycle, so a stalled response holds back only the next
// request. The history shift, the four-entry wrapping sum and the window
// compares are combinational, ahead of the response register. Register
// writes are always taken and apply to the next request.
module pulse_oscillator_trim_tracker_top import pott_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pott_req_if.sink    req_if,
   pott_rsp_if.source  rsp_if,
   pott_csr_if.sink    csr_if
);

   cfg_type                  cfg_ff;
   logic [WIDTH_W-1:0]       hist_ff [AVG_DEPTH];
   logic [WIDTH_W-1:0]       hist_in [AVG_DEPTH];
   logic [HOLD_W-1:0]        hold_ff;
   logic [HOLD_W-1:0]        hold_in;
   logic signed [TRIM_W-1:0] trim_ff;
   logic signed [TRIM_W-1:0] trim_in;
   logic                     lock_ff;
   logic                     lock_in;
   logic                     rsp_valid_ff;
   logic                     eval_ff;
   logic                     eval_in;

   logic                     req_take;
   logic                     width_ok;
   logic [WIDTH_W-1:0]       sum;
   logic [WIDTH_W-1:0]       avg;
   decision_type             decision;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign width_ok     = req_if.pulse_width > cfg_ff.accept_threshold;
   assign csr_if.ready = 1'b1;

   // The average includes the width that arrives with this request.
   always_comb begin
      for (int k = 0; k < AVG_DEPTH - 1; k++) begin
         hist_in[k] = hist_ff[k + 1];
      end
      hist_in[AVG_DEPTH-1] = req_if.pulse_width;
      sum = '0;
      for (int k = 0; k < AVG_DEPTH; k++) begin
         sum = sum + hist_in[k];
      end
      avg = sum >> AVG_SHIFT;
   end

   pott_decide u_decide (
      .avg      (avg),
      .trim_cur (trim_ff),
      .lock_cur (lock_ff),
      .cfg      (cfg_ff),
      .decision (decision)
   );

   always_comb begin
      hold_in = hold_ff;
      trim_in = trim_ff;
      lock_in = lock_ff;
      eval_in = 1'b0;
      if (width_ok) begin
         if (hold_ff != '0) begin
            hold_in = hold_ff - 1'b1;
         end else begin
            eval_in = 1'b1;
            trim_in = decision.trim;
            lock_in = decision.lock;
            hold_in = decision.hold_zero ? '0 : HOLD_RELOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accept_threshold <= RST_ACCEPT_THRESHOLD;
         cfg_ff.coarse_low       <= RST_COARSE_LOW;
         cfg_ff.coarse_high      <= RST_COARSE_HIGH;
         cfg_ff.fine_low         <= RST_FINE_LOW;
         cfg_ff.fine_high        <= RST_FINE_HIGH;
         cfg_ff.coarse_step      <= RST_COARSE_STEP;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ACCEPT_THRESHOLD: cfg_ff.accept_threshold <= csr_if.data;
            CSR_COARSE_LOW:       cfg_ff.coarse_low       <= csr_if.data;
            CSR_COARSE_HIGH:      cfg_ff.coarse_high      <= csr_if.data;
            CSR_FINE_LOW:         cfg_ff.fine_low         <= csr_if.data;
            CSR_FINE_HIGH:        cfg_ff.fine_high        <= csr_if.data;
            CSR_COARSE_STEP:      cfg_ff.coarse_step      <= csr_if.data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_RELOAD;
         trim_ff      <= '0;
         lock_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            hold_ff      <= hold_in;
            trim_ff      <= trim_in;
            lock_ff      <= lock_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         eval_ff <= eval_in;
         if (width_ok) begin
            hist_ff <= hist_in;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.trim      = trim_ff;
   assign rsp_if.locked    = lock_ff;
   assign rsp_if.evaluated = eval_ff;

   // Of the evaluations, only one inside the fine window empties the holdoff, and it sets the lock.
   a_lock_clears_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && eval_ff && hold_ff == '0 |-> lock_ff)
      else $error("holdoff cleared without setting the lock");

   // Any other evaluation reloads the full holdoff.
   a_miss_reloads_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && eval_ff && !lock_ff |-> hold_ff == HOLD_RELOAD)
      else $error("holdoff not reloaded after an evaluation outside the fine window");

   // A rejected width leaves the trim and lock untouched.
   a_reject_holds_trim: assert property (@(posedge clock) disable iff (reset)
      req_take && !width_ok |=> $stable(trim_ff) && $stable(lock_ff) && !eval_ff)
      else $error("rejected width changed the trim state");

   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hold_ff <= HOLD_RELOAD)
      else $error("holdoff count above the history depth");

endmodule

// ===== test/tb_pulse_oscillator_trim_tracker_top.sv =====
// Self-checking testbench for the pulse oscillator trim tracker.
// Depends on pott_pkg, the channel interfaces in pott_if and the top level;
// an in-bench model of the tracker predicts every response.
module tb_pulse_oscillator_trim_tracker_top;
   import pott_pkg::*;

   typedef struct packed {
      logic signed [TRIM_W-1:0] trim;
      logic                     locked;
      logic                     evaluated;
   } trim_result_t;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int GAP_MAX     = 15;
   localparam int DRAIN_LIMIT = 5000;
   localparam int PRINT_LIMIT = 40;

   logic clock;
   logic reset;

   pott_req_if req_if ();
   pott_rsp_if rsp_if ();
   pott_csr_if csr_if ();

   pulse_oscillator_trim_tracker_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Shadow of the tracker state and its registers.
   cfg_type            csr_shadow;
   logic [WIDTH_W-1:0] recent_widths [AVG_DEPTH];
   logic [HOLD_W-1:0]  holdoff_left;
   logic [TRIM_W-1:0]  trim_code;
   logic               lock_state;

   trim_result_t pending_trims [$];
   int           err_count;
   bit           req_gaps;
   bit           rsp_stalls;
   int           rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb_pulse_oscillator_trim_tracker_top: FAIL");
      $finish;
   end

   // Applies one accepted width to the shadow state and returns the response.
   function automatic trim_result_t track_width(input logic [WIDTH_W-1:0] w);
      trim_result_t       r;
      logic [WIDTH_W-1:0] sum;
      logic [WIDTH_W-1:0] avg;
      int                 biased;
      r.evaluated = 1'b0;
      if (w > csr_shadow.accept_threshold) begin
         for (int k = 0; k < AVG_DEPTH - 1; k++) recent_widths[k] = recent_widths[k + 1];
         recent_widths[AVG_DEPTH - 1] = w;
         if (holdoff_left != '0) begin
            holdoff_left = holdoff_left - 1'b1;
         end else begin
            sum = '0;
            for (int k = 0; k < AVG_DEPTH; k++) sum = sum + recent_widths[k];
            avg = WIDTH_W'(sum / AVG_DEPTH);
            holdoff_left = HOLD_RELOAD;
            biased = int'(trim_code ^ TRIM_BIAS);
            if (avg < csr_shadow.coarse_low) begin
               lock_state = 1'b0;
               biased = biased + int'(csr_shadow.coarse_step);
            end else if (avg > csr_shadow.coarse_high) begin
               lock_state = 1'b0;
               biased = biased - int'(csr_shadow.coarse_step);
            end else if (avg < csr_shadow.fine_low) begin
               biased = biased + 1;
            end else if (avg > csr_shadow.fine_high) begin
               biased = biased - 1;
            end else begin
               holdoff_left = '0;
               lock_state = 1'b1;
            end
            if (biased < 0) begin
               biased = 0;
            end else if (biased > int'(TRIM_BIASED_MAX)) begin
               biased = int'(TRIM_BIASED_MAX);
            end
            trim_code = TRIM_W'(biased) ^ TRIM_BIAS;
            r.evaluated = 1'b1;
         end
      end
      r.trim = trim_code;
      r.locked = lock_state;
      return r;
   endfunction

   // A width scattered around a center, mostly close enough to evaluate near the windows.
   function automatic logic [WIDTH_W-1:0] near(input logic [WIDTH_W-1:0] center);
      int spread;
      case ($urandom_range(0, 4))
         0: spread = 2;
         1: spread = 8;
         2: spread = 30;
         3: spread = 150;
         default: spread = 2000;
      endcase
      return center + WIDTH_W'($urandom_range(0, 2 * spread)) - WIDTH_W'(spread);
   endfunction

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic send_width(input logic [WIDTH_W-1:0] w);
      int gap;
      gap = req_gaps ? $urandom_range(0, GAP_MAX) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pulse_width <= w;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_trims.push_back(track_width(w));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_ACCEPT_THRESHOLD: csr_shadow.accept_threshold = value;
         CSR_COARSE_LOW:       csr_shadow.coarse_low = value;
         CSR_COARSE_HIGH:      csr_shadow.coarse_high = value;
         CSR_FINE_LOW:         csr_shadow.fine_low = value;
         CSR_FINE_HIGH:        csr_shadow.fine_high = value;
         CSR_COARSE_STEP:      csr_shadow.coarse_step = value[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_windows(input logic [WIDTH_W-1:0] thr, input logic [WIDTH_W-1:0] clow,
                              input logic [WIDTH_W-1:0] chigh, input logic [WIDTH_W-1:0] flow,
                              input logic [WIDTH_W-1:0] fhigh, input logic [CSR_DAT_W-1:0] step);
      write_reg(CSR_ACCEPT_THRESHOLD, thr);
      write_reg(CSR_COARSE_LOW, clow);
      write_reg(CSR_COARSE_HIGH, chigh);
      write_reg(CSR_FINE_LOW, flow);
      write_reg(CSR_FINE_HIGH, fhigh);
      write_reg(CSR_COARSE_STEP, step);
   endtask

   // Stops offering requests and waits until every response is back.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_trims.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (2) @(negedge clock);
   endtask

   // Mostly well-formed tracking around a center, with some rejected and wild widths.
   task automatic track_stream(input int count, input logic [WIDTH_W-1:0] center);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            send_width(near(center));
         end else if (pick == 8) begin
            send_width(WIDTH_W'($urandom_range(0, csr_shadow.accept_threshold)));
         end else begin
            send_width(WIDTH_W'($urandom));
         end
      end
   endtask

   task automatic random_windows(output logic [WIDTH_W-1:0] center);
      logic [WIDTH_W-1:0] c;
      c = WIDTH_W'($urandom_range(3000, 62000));
      set_windows(WIDTH_W'($urandom_range(0, c - 1000)),
                  c - WIDTH_W'($urandom_range(8, 200)), c + WIDTH_W'($urandom_range(8, 200)),
                  c - WIDTH_W'($urandom_range(0, 6)), c + WIDTH_W'($urandom_range(0, 6)),
                  CSR_DAT_W'($urandom_range(0, 31)));
      center = c;
   endtask

   task automatic restore_defaults();
      set_windows(RST_ACCEPT_THRESHOLD, RST_COARSE_LOW, RST_COARSE_HIGH, RST_FINE_LOW,
                  RST_FINE_HIGH, CSR_DAT_W'(RST_COARSE_STEP));
   endtask

   task automatic test_directed_windows();
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      // Widths at and below the threshold change nothing.
      send_width('0);
      send_width(RST_ACCEPT_THRESHOLD);
      // The four accepted widths after reset only use up the holdoff.
      send_width('1);
      repeat (3) send_width(16'd2624);
      // Inside the fine window the lock sets and the next width evaluates at once.
      send_width(16'd2624);
      send_width(16'd2620);
      // A fine move up keeps the lock.
      send_width(16'd2610);
      send_width(RST_ACCEPT_THRESHOLD + 16'd1);
      repeat (4) send_width(16'd2700);
      send_width(RST_ACCEPT_THRESHOLD);
      repeat (5) send_width(16'd2630);
      repeat (5) send_width(16'd2200);
      settle();
   endtask

   task automatic test_tracking_defaults();
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      track_stream(80, 16'd2624);
      settle();
   endtask

   task automatic test_random_windows();
      logic [WIDTH_W-1:0] center;
      for (int phase = 0; phase < 3; phase++) begin
         // The first phase runs at full rate on both sides.
         req_gaps = (phase != 0);
         rsp_stalls = (phase != 0);
         random_windows(center);
         track_stream(50, center);
         settle();
      end
   endtask

   task automatic test_trim_saturation();
      req_gaps = 1'b0;
      rsp_stalls = 1'b1;
      set_windows(16'd100, RST_COARSE_LOW, RST_COARSE_HIGH, RST_FINE_LOW, RST_FINE_HIGH,
                  CSR_DAT_W'(31));
      for (int round = 0; round < 4; round++) begin
         for (int i = 0; i < 15; i++) begin
            if (round[0] == 1'b0) begin
               send_width(WIDTH_W'($urandom_range(300, 2000)));
            end else begin
               send_width(WIDTH_W'($urandom_range(3000, 10000)));
            end
         end
      end
      settle();
   endtask

   task automatic test_register_extremes();
      req_gaps = 1'b1;
      rsp_stalls = 1'b0;
      // Every average falls inside the fine window, so the trim never moves.
      set_windows('0, '0, '1, '0, '1, '0);
      send_width('0);
      send_width('1);
      repeat (18) send_width(WIDTH_W'($urandom));
      settle();
      // Nothing can pass the highest threshold.
      set_windows('1, '1, '0, '1, '0, CSR_DAT_W'(31));
      send_width('1);
      repeat (9) send_width(WIDTH_W'($urandom));
      settle();
      // Every evaluation raises by the largest step; wide widths wrap the sum.
      set_windows('0, '1, '0, '1, '0, CSR_DAT_W'(31));
      repeat (20) send_width(WIDTH_W'($urandom));
      settle();
      set_windows(WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom),
                  WIDTH_W'($urandom), WIDTH_W'($urandom), CSR_DAT_W'($urandom));
      repeat (40) send_width(WIDTH_W'($urandom));
      settle();
      // Spare indexes are ignored and the step keeps only its low bits.
      restore_defaults();
      write_reg(CSR_SPARE_LO, CSR_DAT_W'($urandom));
      write_reg(CSR_SPARE_HI, CSR_DAT_W'($urandom));
      write_reg(CSR_COARSE_STEP, 16'hffe5);
      track_stream(20, 16'd2624);
      settle();
   endtask

   task automatic test_response_backpressure();
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      restore_defaults();
      // The receiver holds off long enough for the block to fill and refuse requests.
      rsp_hold = 80;
      track_stream(30, 16'd2624);
      settle();
   endtask

   task automatic test_mixed_random();
      logic [WIDTH_W-1:0] center;
      for (int phase = 0; phase < 3; phase++) begin
         req_gaps = 1'($urandom_range(0, 1));
         rsp_stalls = 1'($urandom_range(0, 1));
         random_windows(center);
         track_stream(40, center);
         settle();
      end
   endtask

   // Receiver: draws a stall before each response, or takes a long hold when asked.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = rsp_stalls ? $urandom_range(0, GAP_MAX) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && reset === 1'b0));
      end
   end

   always @(posedge clock) begin : check_responses
      trim_result_t want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_trims.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_trims.pop_front();
            if (rsp_if.trim !== want.trim)
               report_mismatch($sformatf("trim %0d, expected %0d", rsp_if.trim, want.trim));
            if (rsp_if.locked !== want.locked)
               report_mismatch($sformatf("locked %b, expected %b", rsp_if.locked, want.locked));
            if (rsp_if.evaluated !== want.evaluated)
               report_mismatch($sformatf("evaluated %b, expected %b", rsp_if.evaluated,
                                         want.evaluated));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pulse_width = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      err_count = 0;
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      rsp_hold = 0;
      csr_shadow = '{RST_ACCEPT_THRESHOLD, RST_COARSE_LOW, RST_COARSE_HIGH, RST_FINE_LOW,
                     RST_FINE_HIGH, RST_COARSE_STEP};
      for (int k = 0; k < AVG_DEPTH; k++) recent_widths[k] = '0;
      holdoff_left = HOLD_RELOAD;
      trim_code = '0;
      lock_state = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_windows();
      test_tracking_defaults();
      test_random_windows();
      test_trim_saturation();
      test_register_extremes();
      test_response_backpressure();
      test_mixed_random();

      settle();
      repeat (4) @(posedge clock);
      if (pending_trims.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_trims.size()));
      if (err_count == 0) begin
         $display("tb_pulse_oscillator_trim_tracker_top: PASS");
      end else begin
         $display("tb_pulse_oscillator_trim_tracker_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/pott_pkg.sv
design/pott_if.sv
design/pott_decide.sv
design/pulse_oscillator_trim_tracker_top.sv
test/tb_pulse_oscillator_trim_tracker_top.sv
